### sv/bhc_pkg.sv
package bhc_pkg;

  // Counter and bin geometry.
  localparam int CountWidth  = 32;
  localparam int NumBins     = 256;
  localparam int SymWidth    = $clog2(NumBins);
  localparam int FuncWidth   = 2;
  localparam int OutCntWidth = 32;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [SymWidth-1:0]   sym_t;

  // Largest counter value; counters stop here instead of wrapping.
  localparam count_t CountMax = {CountWidth{1'b1}};

  // Operation codes carried by each request. The unused code acts as a read.
  typedef enum logic [FuncWidth-1:0] {
    FUNC_COUNT      = 2'd0,
    FUNC_READ       = 2'd1,
    FUNC_READ_CLEAR = 2'd2
  } func_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_RMW
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture the request and start the bin read
    logic commit;  // write the bin back and load the result register
  } bhc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } bhc_status_t;

endpackage

### sv/byte_histogram_counter.sv
// Histogram of 256 byte-value bins with saturating counters. Each request
// counts a byte, reads a bin, or reads and clears it, and returns one result
// with the bin's count (after counting, or before clearing) and a flag that
// marks the maximum count. A request is handled in two steps: the first reads
// the counter memory into a register, and the second updates the bin, writes
// it back and loads the result register once that register has room, so a new
// request is taken only after the last one has committed. All bins read as
// zero right after reset through one valid bit per bin, so no clearing pass is
// needed.
module byte_histogram_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bhc_pkg::FuncWidth-1:0]    func_i,
  input  logic [bhc_pkg::SymWidth-1:0]     symbol_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bhc_pkg::SymWidth-1:0]     bin_symbol_o,
  output logic [bhc_pkg::OutCntWidth-1:0]  bin_count_o,
  output logic                             saturated_o
);
  import bhc_pkg::*;

  bhc_cmd_t    cmd;
  bhc_status_t status;

  // Sequencing of each request.
  bhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Counter memory, update logic and result register.
  bhc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .symbol_i     (symbol_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bin_symbol_o (bin_symbol_o),
    .bin_count_o  (bin_count_o),
    .saturated_o  (saturated_o)
  );

endmodule

### sv/bhc_ctrl.sv
module bhc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output bhc_pkg::bhc_cmd_t    cmd_o,
  input  bhc_pkg::bhc_status_t status_i
);
  import bhc_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. A request is taken in idle; the bin read
  // completes in the next cycle, and the update commits once the result
  // register has room.
  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        cmd_o.commit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/bhc_datapath.sv
module bhc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bhc_pkg::bhc_cmd_t                cmd_i,
  output bhc_pkg::bhc_status_t             status_o,
  input  logic [bhc_pkg::FuncWidth-1:0]    func_i,
  input  logic [bhc_pkg::SymWidth-1:0]     symbol_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bhc_pkg::SymWidth-1:0]     bin_symbol_o,
  output logic [bhc_pkg::OutCntWidth-1:0]  bin_count_o,
  output logic                             saturated_o
);
  import bhc_pkg::*;

  // Counter memory and one valid bit per bin; an invalid bin reads as zero.
  count_t                  bin_mem [NumBins];
  logic   [NumBins-1:0]    bin_valid_q;

  // Request capture and registered read data.
  logic [FuncWidth-1:0]    func_q;
  sym_t                    sym_q;
  count_t                  rd_data_q;
  logic                    rd_valid_q;

  // Result register.
  logic                    out_valid_q;
  sym_t                    out_sym_q;
  logic [OutCntWidth-1:0]  out_cnt_q;
  logic                    out_sat_q;

  count_t                  cur_cnt;
  count_t                  inc_cnt;
  count_t                  rep_cnt;
  count_t                  wr_cnt;
  logic                    wr_en;

  // Capture the request and read its bin.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q     <= func_i;
      sym_q      <= symbol_i;
      rd_data_q  <= bin_mem[symbol_i];
      rd_valid_q <= bin_valid_q[symbol_i];
    end
  end

  // Saturating update of the addressed bin.
  always_comb begin
    cur_cnt = rd_valid_q ? rd_data_q : '0;
    inc_cnt = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + count_t'(1);
    rep_cnt = cur_cnt;
    wr_cnt  = cur_cnt;
    wr_en   = 1'b0;
    case (func_q)
      FUNC_COUNT: begin
        rep_cnt = inc_cnt;
        wr_cnt  = inc_cnt;
        wr_en   = cmd_i.commit;
      end
      FUNC_READ_CLEAR: begin
        wr_cnt = '0;
        wr_en  = cmd_i.commit;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Counter memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem[sym_q] <= wr_cnt;
    end
  end

  // Valid bits: all bins read as zero right after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= '0;
    end else if (wr_en) begin
      bin_valid_q[sym_q] <= 1'b1;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_sym_q <= sym_q;
      out_cnt_q <= OutCntWidth'(rep_cnt);
      out_sat_q <= (rep_cnt == CountMax);
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign bin_symbol_o = out_sym_q;
  assign bin_count_o  = out_cnt_q;
  assign saturated_o  = out_sat_q;

`ifndef ASSERT_OFF
  // A saturated result always carries an all-ones count.
  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sat_q |-> out_cnt_q == OutCntWidth'(CountMax))
    else $error("saturated result without maximum count");

  // A commit always leaves a result waiting.
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not load the result register");

  // A counted bin is valid afterwards.
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && func_q == FUNC_COUNT |=> bin_valid_q[$past(sym_q)])
    else $error("counted bin not marked valid");

  // A request is never taken in the cycle another one commits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.accept && cmd_i.commit))
    else $error("accept and commit in the same cycle");
`endif

endmodule

### dv/bhc_checker.sv
// Watches both channels of the byte histogram counter, keeps its own copy of
// the 256 bins, and compares every result against the oldest prediction.
module bhc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [bhc_pkg::FuncWidth-1:0]   func_i,
  input  logic [bhc_pkg::SymWidth-1:0]    symbol_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [bhc_pkg::SymWidth-1:0]    bin_symbol_i,
  input  logic [bhc_pkg::OutCntWidth-1:0] bin_count_i,
  input  logic                            saturated_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import bhc_pkg::*;

  typedef struct packed {
    sym_t                   symbol;
    logic [OutCntWidth-1:0] count;
    logic                   saturated;
  } bin_report_t;

  count_t      bin_model [NumBins];
  bin_report_t bin_reports_due [$];
  int unsigned mismatch_count = 0;

  // One line per mismatch, and one more tally toward the failure count.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Applies one request to the bin model and returns the result it must cause.
  function automatic bin_report_t count_bin(input logic [FuncWidth-1:0] f, input sym_t s);
    count_t      c;
    bin_report_t r;
    c = bin_model[s];
    case (func_e'(f))
      FUNC_COUNT: begin
        if (c != CountMax) begin
          c = c + count_t'(1);
        end
        bin_model[s] = c;
      end
      FUNC_READ_CLEAR: begin
        bin_model[s] = '0;
      end
      // A plain read and the spare code leave the bin alone.
      default: ;
    endcase
    r.symbol    = s;
    r.count     = OutCntWidth'(c);
    r.saturated = (c == CountMax);
    return r;
  endfunction

  // Compares one accepted result with the oldest prediction, field by field.
  task automatic check_report();
    bin_report_t exp_r;
    if (bin_reports_due.size() == 0) begin
      report_mismatch($sformatf("result for bin %0d with no request outstanding",
                                bin_symbol_i));
    end else begin
      exp_r = bin_reports_due.pop_front();
      if (bin_symbol_i !== exp_r.symbol) begin
        report_mismatch($sformatf("bin_symbol %0d, expected %0d", bin_symbol_i,
                                  exp_r.symbol));
      end
      if (bin_count_i !== exp_r.count) begin
        report_mismatch($sformatf("bin %0d: bin_count %0d, expected %0d", exp_r.symbol,
                                  bin_count_i, exp_r.count));
      end
      if (saturated_i !== exp_r.saturated) begin
        report_mismatch($sformatf("bin %0d: saturated %b, expected %b", exp_r.symbol,
                                  saturated_i, exp_r.saturated));
      end
    end
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_model = '{default: '0};
      bin_reports_due.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_report();
      end
      if (in_valid_i && !in_stall_i) begin
        bin_reports_due = {bin_reports_due, count_bin(func_i, symbol_i)};
      end
      pending_o    <= bin_reports_due.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

### dv/tb_byte_histogram_counter.sv
// Stimulus and verdict for the byte histogram counter; checking is done by
// the checker instance beside the block.
module tb_byte_histogram_counter;
  import bhc_pkg::*;

  // The unused operation code, which the block must treat as a read.
  localparam logic [FuncWidth-1:0] FuncSpare = 2'd3;

  localparam int unsigned RandomItems   = 1000;
  localparam int unsigned HotBins       = 8;
  localparam int          HotIdxWidth   = $clog2(HotBins);
  localparam int unsigned HoldOffStart  = 600;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned SinkQuietLo   = 1400;
  localparam int unsigned SinkQuietHi   = 1900;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 4000;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   req_valid   = 1'b0;
  logic                   req_stall;
  logic [FuncWidth-1:0]   req_func    = '0;
  sym_t                   req_symbol  = '0;
  logic                   rsp_valid;
  logic                   rsp_stall   = 1'b0;
  sym_t                   rsp_symbol;
  logic [OutCntWidth-1:0] rsp_count;
  logic                   rsp_saturated;
  int unsigned            fail_count;
  int unsigned            reports_due;

  logic                   sender_gaps = 1'b1;
  int unsigned            req_count [4] = '{default: 0};

  // Clock with a period of ten time units.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  byte_histogram_counter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_valid),
    .in_stall_o   (req_stall),
    .func_i       (req_func),
    .symbol_i     (req_symbol),
    .out_valid_o  (rsp_valid),
    .out_stall_i  (rsp_stall),
    .bin_symbol_o (rsp_symbol),
    .bin_count_o  (rsp_count),
    .saturated_o  (rsp_saturated)
  );

  bhc_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_valid),
    .in_stall_i   (req_stall),
    .func_i       (req_func),
    .symbol_i     (req_symbol),
    .out_valid_i  (rsp_valid),
    .out_stall_i  (rsp_stall),
    .bin_symbol_i (rsp_symbol),
    .bin_count_i  (rsp_count),
    .saturated_i  (rsp_saturated),
    .fail_count_o (fail_count),
    .pending_o    (reports_due)
  );

  // Offers one request and returns at the edge that accepts it. Valid stays
  // high afterwards so that back-to-back requests need no second assignment.
  task automatic send_request(input logic [FuncWidth-1:0] f, input sym_t s);
    if (sender_gaps && $urandom_range(99) < 12) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    req_valid  <= 1'b1;
    req_func   <= f;
    req_symbol <= s;
    req_count[f]++;
    do @(posedge clk_i); while (req_stall);
  endtask

  // The result side stalls at random, holds off once for a long stretch so
  // that the block backs up into its input, and has a window with no stalls.
  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == HoldOffStart) begin
        rsp_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        cyc += HoldOffCycles;
        rsp_stall <= 1'b0;
      end else if (cyc >= SinkQuietLo && cyc < SinkQuietHi) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 12);
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: nothing moved on either channel for %0d cycles.", WatchdogLimit);
    $display("[byte_histogram_counter] ERROR");
    $finish;
  end

  initial begin : stimulus
    sym_t                 hot_bins [HotBins];
    logic [FuncWidth-1:0] f;
    sym_t                 s;
    int unsigned          pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests: both extreme bins, every code, clearing twice,
    // a bin that was never touched, and the spare code leaving a bin alone.
    send_request(FUNC_COUNT,      8'h00);
    send_request(FUNC_COUNT,      8'h00);
    send_request(FUNC_COUNT,      8'hff);
    send_request(FUNC_READ,       8'h00);
    send_request(FUNC_READ,       8'hff);
    send_request(FUNC_READ,       8'h80);
    send_request(FuncSpare,       8'h00);
    send_request(FUNC_READ,       8'h00);
    send_request(FUNC_READ_CLEAR, 8'h00);
    send_request(FUNC_READ,       8'h00);
    send_request(FUNC_READ_CLEAR, 8'h00);
    send_request(FUNC_COUNT,      8'h00);
    send_request(FUNC_COUNT,      8'haa);
    send_request(FUNC_COUNT,      8'h55);
    send_request(FUNC_COUNT,      8'haa);
    send_request(FUNC_READ_CLEAR, 8'haa);
    send_request(FuncSpare,       8'h55);
    send_request(FuncSpare,       8'hff);
    send_request(FUNC_READ_CLEAR, 8'hff);
    send_request(FUNC_COUNT,      8'hff);
    send_request(FUNC_READ,       8'hff);
    send_request(FUNC_COUNT,      8'h01);
    send_request(FUNC_READ_CLEAR, 8'h01);

    // A few hot bins, the extremes among them, let counts build up so that
    // reads and clears mostly see nonzero bins.
    hot_bins[0] = 8'h00;
    hot_bins[1] = 8'hff;
    for (int i = 2; i < HotBins; i++) begin
      hot_bins[i] = sym_t'($urandom_range(255));
    end

    // Random requests, with one stretch where the sender never pauses.
    for (int n = 0; n < RandomItems; n++) begin
      sender_gaps = !(n >= 600 && n < 800);
      pick = $urandom_range(99);
      if (pick < 60) begin
        f = FUNC_COUNT;
      end else if (pick < 80) begin
        f = FUNC_READ;
      end else if (pick < 95) begin
        f = FUNC_READ_CLEAR;
      end else begin
        f = FuncSpare;
      end
      if ($urandom_range(99) < 70) begin
        s = hot_bins[HotIdxWidth'($urandom_range(HotBins - 1))];
      end else begin
        s = sym_t'($urandom_range(255));
      end
      send_request(f, s);
    end
    req_valid <= 1'b0;

    // Wait for every predicted result, then let stray results show up before the verdict.
    do @(posedge clk_i); while (reports_due != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d count, %0d read, %0d read-and-clear and %0d spare-code requests.",
             req_count[FUNC_COUNT], req_count[FUNC_READ], req_count[FUNC_READ_CLEAR],
             req_count[FuncSpare]);
    $display("The result side held off once for %0d cycles; %0d-bit counters stay %s",
             HoldOffCycles, CountWidth, "far below their maximum in a run this short.");
    if (fail_count == 0) begin
      $display("[byte_histogram_counter] OK");
    end else begin
      $display("[byte_histogram_counter] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/bhc_pkg.sv
sv/bhc_ctrl.sv
sv/bhc_datapath.sv
sv/byte_histogram_counter.sv
dv/bhc_checker.sv
dv/tb_byte_histogram_counter.sv
